### rtl/core/wsfp_pkg.sv
// shared types, codes and constants of the websocket frame parser
package wsfp_pkg;

	// header buffer geometry
	localparam int HDR_BYTES  = 14;
	localparam int LEN_W      = 63;
	localparam int KEY_W      = 32;
	localparam int S_TDATA_W  = 8;
	localparam int M_TDATA_W  = 184;
	localparam int M_TUSER_W  = 2;
	localparam int CFG_IDX_W  = 2;

	typedef logic [LEN_W-1:0] len_t;
	typedef logic [HDR_BYTES-1:0][7:0] hdr_buf_t;

	// error codes
	localparam logic [3:0] ERR_NONE         = 4'd0;
	localparam logic [3:0] ERR_NONCANON_LEN = 4'd1;
	localparam logic [3:0] ERR_BAD_LEN64    = 4'd2;
	localparam logic [3:0] ERR_RSVD_OPCODE  = 4'd3;
	localparam logic [3:0] ERR_RSV_BITS     = 4'd4;
	localparam logic [3:0] ERR_MISSING_MASK = 4'd5;
	localparam logic [3:0] ERR_UNEXP_MASK   = 4'd6;
	localparam logic [3:0] ERR_FRAG_CTRL    = 4'd7;
	localparam logic [3:0] ERR_CTRL_LARGE   = 4'd8;
	localparam logic [3:0] ERR_FRAME_LARGE  = 4'd9;
	localparam logic [3:0] ERR_UNEXP_CONT   = 4'd10;
	localparam logic [3:0] ERR_DATA_IN_FRAG = 4'd11;

	// opcodes
	localparam logic [3:0] OP_CONT  = 4'd0;
	localparam logic [3:0] OP_TEXT  = 4'd1;
	localparam logic [3:0] OP_BIN   = 4'd2;
	localparam logic [3:0] OP_CLOSE = 4'd8;
	localparam logic [3:0] OP_PING  = 4'd9;
	localparam logic [3:0] OP_PONG  = 4'd10;

	// length field codes
	localparam logic [6:0] LEN_CODE_16   = 7'd126;
	localparam logic [6:0] LEN_CODE_64   = 7'd127;
	localparam logic [6:0] LEN_MAX_SMALL = 7'd125;

	// input kinds
	localparam logic FUNC_BYTE  = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROLE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RSV_MASK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 2'd2;

	localparam logic ROLE_CLIENT = 1'b0;
	localparam logic ROLE_SERVER = 1'b1;

	typedef struct packed {
		logic       role;
		logic [2:0] rsv_mask;
		len_t       max_bytes;
	} cfg_t;

	// decoded header with its check verdict
	typedef struct packed {
		logic [3:0]       err;
		logic             fin;
		logic [2:0]       rsv;
		logic [3:0]       op;
		logic             masked;
		logic [KEY_W-1:0] key;
		len_t             len;
	} hdr_t;

	typedef struct packed {
		logic [3:0]       error;
		logic             hdr_done;
		logic             payload_valid;
		logic [7:0]       payload_byte;
		len_t             pay_offset;
		logic             frame_end;
		logic             fin_flag;
		logic [2:0]       rsv_bits;
		logic [3:0]       frame_opcode;
		logic             is_masked;
		logic [KEY_W-1:0] mask_key;
		len_t             payload_length;
	} result_t;

endpackage

### rtl/core/wsfp_cfg_regs.sv
// configuration registers: role, permitted rsv bits, frame size limit
module wsfp_cfg_regs
	import wsfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  len_t                 cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.role      <= ROLE_SERVER;
			cfg_q.rsv_mask  <= 3'd0;
			cfg_q.max_bytes <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROLE:     cfg_q.role      <= cfg_data[0];
				CFG_RSV_MASK: cfg_q.rsv_mask  <= cfg_data[2:0];
				CFG_MAX_LEN:  cfg_q.max_bytes <= cfg_data;
				default:      cfg_q           <= cfg_q;
			endcase
		end
	end

endmodule

### rtl/core/wsfp_hdr_check.sv
// decodes a complete header buffer and runs the header checks in priority order
module wsfp_hdr_check
	import wsfp_pkg::*;
(
	input  hdr_buf_t hb,
	input  cfg_t     cfg,
	input  logic     in_frag,
	output hdr_t     hdr
);

	always_comb begin
		logic [6:0]       lc;
		logic [15:0]      len16;
		len_t             len64;
		logic [KEY_W-1:0] key;
		logic [3:0]       err;
		logic             ctrl;
		logic             too_big;

		lc    = hb[1][6:0];
		len16 = {hb[2], hb[3]};
		len64 = {hb[2][6:0], hb[3], hb[4], hb[5], hb[6], hb[7], hb[8], hb[9]};
		err   = ERR_NONE;

		hdr.fin    = hb[0][7];
		hdr.rsv    = hb[0][6:4];
		hdr.op     = hb[0][3:0];
		hdr.masked = hb[1][7];

		// length decode and canonical form checks
		if (lc == LEN_CODE_16) begin
			hdr.len = {{(LEN_W-16){1'b0}}, len16};
			key     = {hb[4], hb[5], hb[6], hb[7]};
			if (len16 <= {9'd0, LEN_MAX_SMALL}) err = ERR_NONCANON_LEN;
		end else if (lc == LEN_CODE_64) begin
			hdr.len = len64;
			key     = {hb[10], hb[11], hb[12], hb[13]};
			if (hb[2][7]) err = ERR_BAD_LEN64;
			else if (len64[LEN_W-1:16] == '0) err = ERR_NONCANON_LEN;
		end else begin
			hdr.len = {{(LEN_W-7){1'b0}}, lc};
			key     = {hb[2], hb[3], hb[4], hb[5]};
		end
		hdr.key = hdr.masked ? key : '0;

		ctrl    = hdr.op[3];
		too_big = (cfg.max_bytes != '0) && (hdr.len > cfg.max_bytes);

		// remaining checks, first failure wins
		if (err != ERR_NONE)
			hdr.err = err;
		else if (!(hdr.op inside {OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG}))
			hdr.err = ERR_RSVD_OPCODE;
		else if ((hdr.rsv & ~cfg.rsv_mask) != 3'd0)
			hdr.err = ERR_RSV_BITS;
		else if (cfg.role == ROLE_SERVER && !hdr.masked)
			hdr.err = ERR_MISSING_MASK;
		else if (cfg.role == ROLE_CLIENT && hdr.masked)
			hdr.err = ERR_UNEXP_MASK;
		else if (ctrl && !hdr.fin)
			hdr.err = ERR_FRAG_CTRL;
		else if (ctrl && hdr.len > {{(LEN_W-7){1'b0}}, LEN_MAX_SMALL})
			hdr.err = ERR_CTRL_LARGE;
		else if (too_big)
			hdr.err = ERR_FRAME_LARGE;
		else if (hdr.op == OP_CONT && !in_frag)
			hdr.err = ERR_UNEXP_CONT;
		else if ((hdr.op == OP_TEXT || hdr.op == OP_BIN) && in_frag)
			hdr.err = ERR_DATA_IN_FRAG;
		else
			hdr.err = ERR_NONE;
	end

endmodule

### rtl/core/wsfp_parser.sv
// parser state: header collection, payload counting, fragmentation and sticky error
module wsfp_parser
	import wsfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       func,
	input  logic [7:0] data_byte,
	input  cfg_t       cfg,
	output result_t    res
);

	hdr_buf_t         hb_q;
	logic [3:0]       count_q;
	len_t             left_q;
	len_t             offset_q;
	logic             in_payload_q;
	logic             in_frag_q;
	logic [3:0]       sticky_q;
	logic             fin_q;
	logic [2:0]       rsv_q;
	logic [3:0]       op_q;
	logic             masked_q;
	logic [KEY_W-1:0] key_q;
	len_t             len_q;

	hdr_buf_t         hb_n;
	logic [3:0]       cnt_n;
	logic [3:0]       need;
	logic             complete;
	hdr_t             hdr;

	logic             hb_we;
	logic [3:0]       count_d;
	len_t             left_d;
	len_t             offset_d;
	logic             in_payload_d;
	logic             in_frag_d;
	logic [3:0]       sticky_d;
	logic             latch_hdr;
	logic             clear;

	// header buffer with the current byte placed
	always_comb begin
		hb_n          = hb_q;
		hb_n[count_q] = data_byte;
	end

	// header size implied by the second byte
	always_comb begin
		need = 4'd2;
		if (hb_n[1][6:0] == LEN_CODE_16) need = 4'd4;
		else if (hb_n[1][6:0] == LEN_CODE_64) need = 4'd10;
		if (hb_n[1][7]) need = need + 4'd4;
	end

	assign cnt_n    = count_q + 4'd1;
	assign complete = (cnt_n >= 4'd2) && (cnt_n == need);

	wsfp_hdr_check u_check (
		.hb      (hb_n),
		.cfg     (cfg),
		.in_frag (in_frag_q),
		.hdr     (hdr)
	);

	// next state and result
	always_comb begin
		hb_we        = 1'b0;
		count_d      = count_q;
		left_d       = left_q;
		offset_d     = offset_q;
		in_payload_d = in_payload_q;
		in_frag_d    = in_frag_q;
		sticky_d     = sticky_q;
		latch_hdr    = 1'b0;
		clear        = 1'b0;

		res                = '0;
		res.fin_flag       = fin_q;
		res.rsv_bits       = rsv_q;
		res.frame_opcode   = op_q;
		res.is_masked      = masked_q;
		res.mask_key       = key_q;
		res.payload_length = len_q;

		if (func == FUNC_CLEAR) begin
			clear        = 1'b1;
			count_d      = 4'd0;
			left_d       = '0;
			offset_d     = '0;
			in_payload_d = 1'b0;
			in_frag_d    = 1'b0;
			sticky_d     = ERR_NONE;
			res          = '0;
		end else if (sticky_q != ERR_NONE) begin
			res.error = sticky_q;
		end else if (!in_payload_q) begin
			// header byte
			hb_we   = 1'b1;
			count_d = cnt_n;
			if (complete) begin
				latch_hdr          = 1'b1;
				res.fin_flag       = hdr.fin;
				res.rsv_bits       = hdr.rsv;
				res.frame_opcode   = hdr.op;
				res.is_masked      = hdr.masked;
				res.mask_key       = hdr.key;
				res.payload_length = hdr.len;
				res.error          = hdr.err;
				if (hdr.err != ERR_NONE) begin
					sticky_d = hdr.err;
				end else begin
					if (hdr.op == OP_CONT) begin
						if (hdr.fin) in_frag_d = 1'b0;
					end else if ((hdr.op == OP_TEXT || hdr.op == OP_BIN) && !hdr.fin) begin
						in_frag_d = 1'b1;
					end
					res.hdr_done     = 1'b1;
					count_d          = 4'd0;
					offset_d         = '0;
					left_d           = hdr.len;
					in_payload_d     = (hdr.len != '0);
					res.frame_end    = (hdr.len == '0);
				end
			end
		end else begin
			// payload byte
			res.payload_valid  = 1'b1;
			res.payload_byte   = data_byte;
			res.pay_offset     = offset_q;
			offset_d           = offset_q + len_t'(1);
			left_d             = left_q - len_t'(1);
			if (left_q == len_t'(1)) begin
				in_payload_d       = 1'b0;
				count_d            = 4'd0;
				res.frame_end      = 1'b1;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= 4'd0;
			left_q       <= '0;
			offset_q     <= '0;
			in_payload_q <= 1'b0;
			in_frag_q    <= 1'b0;
			sticky_q     <= ERR_NONE;
			fin_q        <= 1'b0;
			rsv_q        <= 3'd0;
			op_q         <= 4'd0;
			masked_q     <= 1'b0;
			key_q        <= '0;
			len_q        <= '0;
		end else if (step) begin
			count_q      <= count_d;
			left_q       <= left_d;
			offset_q     <= offset_d;
			in_payload_q <= in_payload_d;
			in_frag_q    <= in_frag_d;
			sticky_q     <= sticky_d;
			if (clear) begin
				fin_q    <= 1'b0;
				rsv_q    <= 3'd0;
				op_q     <= 4'd0;
				masked_q <= 1'b0;
				key_q    <= '0;
				len_q    <= '0;
			end else if (latch_hdr) begin
				fin_q    <= hdr.fin;
				rsv_q    <= hdr.rsv;
				op_q     <= hdr.op;
				masked_q <= hdr.masked;
				key_q    <= hdr.key;
				len_q    <= hdr.len;
			end
		end
	end

	// header bytes, only positions below the fill count are ever read
	always_ff @(posedge clk) begin
		if (step && hb_we) hb_q <= hb_n;
	end

endmodule

### rtl/core/websocket_frame_parser.sv
// top level: input register, parser state and output register of the frame parser
//
// Usage:
//   s_tvalid/s_tready/s_tdata/s_tuser carry one stream item per accepted cycle:
//   s_tdata is the received byte, s_tuser set means clear the parser state and
//   any sticky error (the byte is then ignored).
//   m_tvalid/m_tready/m_tdata/m_tuser/m_tlast return exactly one result item per
//   input item, in order. m_tlast marks the byte that ends a frame, m_tuser
//   flags a completed valid header and a payload byte.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the role, permitted rsv bits
//   and frame size limit; write them only while no item is in flight.
// Order: an accepted item passes the input register, then the output register, where
//   its result is offered on m_* until m_tready takes it.
// Throughput: one item per cycle while m_tready is high; every header check and
//   counter update is done combinationally between the input and output registers.
// Reset: arst_n clears the parser control state, empties both registers and sets the
//   configuration to server role, no rsv bits, no size limit.
// Stall: while m_tready is low the output register holds its result, the input
//   register still takes one more item, then s_tready drops until m_tready returns.
module websocket_frame_parser
	import wsfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
	input  logic                 s_tuser,   // [0] func
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [3:0] error, [11:4] payload_byte, [74:12] pay_offset, [75] fin_flag,
	// [78:76] rsv_bits, [82:79] frame_opcode, [83] is_masked, [115:84] mask_key,
	// [178:116] payload_length, [183:179] zero
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [M_TUSER_W-1:0] m_tuser,   // [0] hdr_done, [1] payload_valid
	output logic                 m_tlast,   // frame_end
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  len_t                 cfg_data
);

	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	result_t    res_q;
	result_t    res;
	cfg_t       cfg;
	logic       step;

	// item moves from input register to output register
	assign step     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	wsfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wsfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.func      (func_s1),
		.data_byte (byte_s1),
		.cfg       (cfg),
		.res       (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) res_q <= res;
	end

	// result packing
	assign m_tvalid = out_valid_q;
	assign m_tlast  = res_q.frame_end;
	assign m_tuser  = {res_q.payload_valid, res_q.hdr_done};
	assign m_tdata  = {5'd0, res_q.payload_length, res_q.mask_key, res_q.is_masked,
			res_q.frame_opcode, res_q.rsv_bits, res_q.fin_flag, res_q.pay_offset,
			res_q.payload_byte, res_q.error};

endmodule

### bench/websocket_frame_parser_test.sv
// self-checking testbench of the websocket frame parser: directed rows, random frames, noise
`timescale 1ns / 1ps

module websocket_frame_parser_test;
	import wsfp_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 6;
	localparam int PHASE_ITEMS  = 240;

	// one directed row, with a typed expectation where pinned is set
	typedef struct packed {
		logic       func;
		logic [7:0] data;
		logic       pinned;
		logic [3:0] err;
		logic       hdr;
		logic       last;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // [7:0] data_byte
	logic                 s_tuser;   // [0] func
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// [3:0] error, [11:4] payload_byte, [74:12] pay_offset, [75] fin_flag,
	// [78:76] rsv_bits, [82:79] frame_opcode, [83] is_masked, [115:84] mask_key,
	// [178:116] payload_length, [183:179] zero
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;   // [0] hdr_done, [1] payload_valid
	logic                 m_tlast;   // frame_end
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	len_t                 cfg_data;

	// parser model state
	logic [7:0] hbuf [HDR_BYTES];
	int         hcnt;
	len_t       left;
	bit         in_pl;
	bit         in_frag;
	logic [3:0] sticky;
	logic             h_fin;
	logic [2:0]       h_rsv;
	logic [3:0]       h_op;
	logic             h_masked;
	logic [KEY_W-1:0] h_key;
	len_t             h_len;

	// register copies
	logic       role;
	logic [2:0] rsv_mask;
	len_t       max_len;

	result_t parsed_results [$];
	int      stream_items = 0;
	int      mismatches = 0;
	int      quiet_cycles = 0;
	int      stall_left = 0;
	bit      idle_on = 1'b1;

	websocket_frame_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] rand_byte();
		logic [7:0] v;
		v = 8'($urandom);
		return v;
	endfunction

	function automatic void close_frame();
		hcnt = 0;
		left = '0;
		in_pl = 1'b0;
	endfunction

	function automatic void clear_parser();
		for (int k = 0; k < HDR_BYTES; k++) hbuf[k] = 8'h00;
		close_frame();
		in_frag = 1'b0;
		sticky = ERR_NONE;
		h_fin = 1'b0;
		h_rsv = '0;
		h_op = OP_CONT;
		h_masked = 1'b0;
		h_key = '0;
		h_len = '0;
	endfunction

	// header bytes needed so far, from the length code and mask bit
	function automatic int header_need();
		int n;
		n = 2;
		if (hcnt < 2) return n;
		if (hbuf[1][6:0] == LEN_CODE_16) n += 2;
		else if (hbuf[1][6:0] == LEN_CODE_64) n += 8;
		if (hbuf[1][7]) n += 4;
		return n;
	endfunction

	// decode the collected header into the latched fields and return its verdict
	function automatic logic [3:0] judge_header();
		logic [6:0]  lc;
		logic [63:0] wide;
		logic [3:0]  e;
		int          pos;
		lc = hbuf[1][6:0];
		wide = '0;
		e = ERR_NONE;
		pos = 2;
		h_fin = hbuf[0][7];
		h_rsv = hbuf[0][6:4];
		h_op = hbuf[0][3:0];
		h_masked = hbuf[1][7];
		h_key = '0;
		if (lc <= LEN_MAX_SMALL) begin
			wide = 64'(lc);
		end else if (lc == LEN_CODE_16) begin
			wide = {48'd0, hbuf[2], hbuf[3]};
			pos = 4;
			if (wide <= 64'(LEN_MAX_SMALL)) e = ERR_NONCANON_LEN;
		end else begin
			if (hbuf[2][7]) e = ERR_BAD_LEN64;
			for (int k = 0; k < 8; k++) wide = {wide[55:0], hbuf[2 + k]};
			wide[63] = 1'b0;
			pos = 10;
			if (e == ERR_NONE && wide <= 64'hFFFF) e = ERR_NONCANON_LEN;
		end
		h_len = wide[LEN_W-1:0];
		if (h_masked) begin
			for (int k = 0; k < 4; k++) h_key = {h_key[KEY_W-9:0], hbuf[pos + k]};
		end
		if (e != ERR_NONE) return e;
		if (!(h_op <= OP_BIN || (h_op >= OP_CLOSE && h_op <= OP_PONG))) return ERR_RSVD_OPCODE;
		if ((h_rsv & ~rsv_mask) != 3'b000) return ERR_RSV_BITS;
		if (role == ROLE_SERVER && !h_masked) return ERR_MISSING_MASK;
		if (role == ROLE_CLIENT && h_masked) return ERR_UNEXP_MASK;
		if (h_op >= OP_CLOSE) begin
			if (!h_fin) return ERR_FRAG_CTRL;
			if (h_len > len_t'(LEN_MAX_SMALL)) return ERR_CTRL_LARGE;
		end
		if (max_len != '0 && h_len > max_len) return ERR_FRAME_LARGE;
		if (h_op == OP_CONT) begin
			if (!in_frag) return ERR_UNEXP_CONT;
		end else if ((h_op == OP_TEXT || h_op == OP_BIN) && in_frag) begin
			return ERR_DATA_IN_FRAG;
		end
		return ERR_NONE;
	endfunction

	// expected result of one accepted stream item, advancing the parser state
	function automatic result_t parse_stream_item(input logic func, input logic [7:0] data);
		result_t r;
		r = '0;
		if (func == FUNC_CLEAR) begin
			clear_parser();
		end else if (sticky != ERR_NONE) begin
			r.error = sticky;
		end else if (!in_pl) begin
			if (hcnt < HDR_BYTES) begin
				hbuf[hcnt] = data;
				hcnt++;
			end
			if (hcnt >= 2 && hcnt >= header_need()) begin
				r.error = judge_header();
				if (r.error != ERR_NONE) begin
					sticky = r.error;
				end else begin
					// track fragmented messages
					if (h_op == OP_CONT) begin
						if (h_fin) in_frag = 1'b0;
					end else if ((h_op == OP_TEXT || h_op == OP_BIN) && !h_fin) begin
						in_frag = 1'b1;
					end
					r.hdr_done = 1'b1;
					left = h_len;
					in_pl = 1'b1;
					if (left == '0) begin
						close_frame();
						r.frame_end = 1'b1;
					end
				end
			end
		end else begin
			r.payload_valid = 1'b1;
			r.payload_byte = data;
			r.pay_offset = h_len - left;
			left = left - 1'b1;
			if (left == '0) begin
				close_frame();
				r.frame_end = 1'b1;
			end
		end
		r.fin_flag = h_fin;
		r.rsv_bits = h_rsv;
		r.frame_opcode = h_op;
		r.is_masked = h_masked;
		r.mask_key = h_key;
		r.payload_length = h_len;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// send one item and queue its expected result once accepted
	task automatic send_item(input logic func, input logic [7:0] data,
			input logic pinned = 1'b0, input logic [3:0] pin_err = ERR_NONE,
			input logic pin_hdr = 1'b0, input logic pin_last = 1'b0);
		result_t r;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		if (func == FUNC_CLEAR || sticky == ERR_NONE) stream_items++;
		r = parse_stream_item(func, data);
		if (pinned) begin
			r.error = pin_err;
			r.hdr_done = pin_hdr;
			r.frame_end = pin_last;
		end
		parsed_results.push_back(r);
	endtask

	// stop sending and let every queued result come out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (parsed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all three registers back to back while the parser is idle
	task automatic apply_setting(input logic new_role, input logic [2:0] new_rsv,
			input len_t new_max);
		logic [CFG_IDX_W-1:0] idx [3];
		len_t                 vals [3];
		idx = '{CFG_ROLE, CFG_RSV_MASK, CFG_MAX_LEN};
		vals = '{len_t'(new_role), len_t'(new_rsv), new_max};
		drain();
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= vals[k];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		role = new_role;
		rsv_mask = new_rsv;
		max_len = new_max;
	endtask

	// leave error, truncated payload or partial header with a clear item
	task automatic recover();
		if (sticky != ERR_NONE) begin
			repeat ($urandom_range(0, 3)) send_item(FUNC_BYTE, rand_byte());
			send_item(FUNC_CLEAR, rand_byte());
		end else if (in_pl || hcnt != 0) begin
			send_item(FUNC_CLEAR, rand_byte());
		end
	endtask

	// one frame, mostly well formed for the current role and fragmentation state
	task automatic send_frame();
		logic [3:0]  op;
		logic        fin;
		logic        msk;
		logic [2:0]  rsv;
		logic [63:0] wide;
		logic [7:0]  hb [$];
		int          lcode;
		int          pick;
		int          n;
		pick = $urandom_range(0, 99);
		if (in_frag ? pick < 60 : pick >= 90) begin
			op = OP_CONT;
		end else if (in_frag ? pick < 90 : pick >= 65) begin
			case ($urandom_range(0, 2))
				0: op = OP_CLOSE;
				1: op = OP_PING;
				default: op = OP_PONG;
			endcase
		end else begin
			op = $urandom_range(0, 1) ? OP_TEXT : OP_BIN;
		end
		if ($urandom_range(0, 39) == 0) begin
			do op = 4'($urandom); while (op <= OP_BIN || (op >= OP_CLOSE && op <= OP_PONG));
		end
		fin = (op >= OP_CLOSE) ? ($urandom_range(0, 19) != 0) : 1'($urandom);
		rsv = 3'($urandom);
		if ($urandom_range(0, 19) != 0) rsv = rsv & rsv_mask;
		msk = ($urandom_range(0, 19) == 0) ? !role : role;

		// payload length and its encoding
		lcode = 0;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			wide = (op >= OP_CLOSE) ? 64'($urandom_range(0, 12)) : 64'($urandom_range(0, 20));
		end else if (pick < 75) begin
			wide = 64'(LEN_MAX_SMALL);
		end else if (pick < 85) begin
			lcode = 1;
			wide = (pick == 84) ? 64'hFFFF : 64'($urandom_range(126, 160));
		end else if (pick < 93) begin
			lcode = 2;
			wide = {$urandom, $urandom};
			wide[63] = 1'b0;
			if (pick == 92) wide = {1'b0, {63{1'b1}}};
			if (wide <= 64'hFFFF) wide[16] = 1'b1;
		end else begin
			// length encodings that the parser must reject
			case ($urandom_range(0, 2))
				0: begin
					lcode = 1;
					wide = 64'($urandom_range(0, 125));
				end
				1: begin
					lcode = 2;
					wide = 64'($urandom_range(0, 16'hFFFF));
				end
				default: begin
					lcode = 2;
					wide = {$urandom, $urandom};
					wide[63] = 1'b1;
				end
			endcase
		end

		hb.push_back({fin, rsv, op});
		case (lcode)
			0: hb.push_back({msk, wide[6:0]});
			1: begin
				hb.push_back({msk, LEN_CODE_16});
				hb.push_back(wide[15:8]);
				hb.push_back(wide[7:0]);
			end
			default: begin
				hb.push_back({msk, LEN_CODE_64});
				for (int k = 7; k >= 0; k--) hb.push_back(wide[8*k +: 8]);
			end
		endcase
		if (msk) repeat (4) hb.push_back(rand_byte());

		// now and then the header is cut short
		n = hb.size();
		if ($urandom_range(0, 19) == 0) n = $urandom_range(1, hb.size() - 1);
		for (int k = 0; k < n; k++) send_item(FUNC_BYTE, hb[k]);

		if (in_pl) begin
			if (h_len <= len_t'(300)) begin
				n = int'(h_len);
				if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
			end else begin
				n = $urandom_range(0, 20);
			end
			repeat (n) send_item(FUNC_BYTE, rand_byte());
		end
		recover();
	endtask

	// random frames, raw noise and lone clears until the phase has its items
	task automatic run_phase(input int count);
		int target;
		int pick;
		target = stream_items + count;
		while (stream_items < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				send_frame();
			end else if (pick < 92) begin
				repeat ($urandom_range(1, 16)) send_item(FUNC_BYTE, rand_byte());
				recover();
			end else begin
				send_item(FUNC_CLEAR, rand_byte());
			end
		end
	endtask

	// output stalls in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 10);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// count cycles in which no item moves on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("websocket_frame_parser test failed");
		$finish;
	end

	// compare each result item with the oldest expectation
	always @(posedge clk) begin : compare_results
		result_t want;
		result_t got;
		if (m_tvalid && m_tready) begin
			got.error = m_tdata[3:0];
			got.hdr_done = m_tuser[0];
			got.payload_valid = m_tuser[1];
			got.payload_byte = m_tdata[11:4];
			got.pay_offset = m_tdata[74:12];
			got.frame_end = m_tlast;
			got.fin_flag = m_tdata[75];
			got.rsv_bits = m_tdata[78:76];
			got.frame_opcode = m_tdata[82:79];
			got.is_masked = m_tdata[83];
			got.mask_key = m_tdata[115:84];
			got.payload_length = m_tdata[178:116];
			if (parsed_results.size() == 0) begin
				$error("result item with no expectation pending");
				mismatches++;
			end else begin
				want = parsed_results.pop_front();
				check_field("error", 64'(want.error), 64'(got.error));
				check_field("hdr_done", 64'(want.hdr_done), 64'(got.hdr_done));
				check_field("payload_valid", 64'(want.payload_valid), 64'(got.payload_valid));
				check_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
				check_field("pay_offset", 64'(want.pay_offset), 64'(got.pay_offset));
				check_field("frame_end", 64'(want.frame_end), 64'(got.frame_end));
				check_field("fin_flag", 64'(want.fin_flag), 64'(got.fin_flag));
				check_field("rsv_bits", 64'(want.rsv_bits), 64'(got.rsv_bits));
				check_field("frame_opcode", 64'(want.frame_opcode), 64'(got.frame_opcode));
				check_field("is_masked", 64'(want.is_masked), 64'(got.is_masked));
				check_field("mask_key", 64'(want.mask_key), 64'(got.mask_key));
				check_field("payload_length", 64'(want.payload_length), 64'(got.payload_length));
			end
		end
	end

	// directed rows under the reset setting: server role, no rsv bits, no limit
	stim_row_t directed_rows [25] = '{
		'{FUNC_BYTE,  8'h81, 1'b1, ERR_NONE,         1'b0, 1'b0},  // fin text
		'{FUNC_BYTE,  8'h80, 1'b1, ERR_NONE,         1'b0, 1'b0},  // masked, empty
		'{FUNC_BYTE,  8'hFF, 1'b1, ERR_NONE,         1'b0, 1'b0},
		'{FUNC_BYTE,  8'h00, 1'b1, ERR_NONE,         1'b0, 1'b0},
		'{FUNC_BYTE,  8'hA5, 1'b1, ERR_NONE,         1'b0, 1'b0},
		'{FUNC_BYTE,  8'h5A, 1'b1, ERR_NONE,         1'b1, 1'b1},  // header and end at once
		'{FUNC_BYTE,  8'h02, 1'b1, ERR_NONE,         1'b0, 1'b0},  // binary, first fragment
		'{FUNC_BYTE,  8'h82, 1'b1, ERR_NONE,         1'b0, 1'b0},
		'{FUNC_BYTE,  8'h12, 1'b1, ERR_NONE,         1'b0, 1'b0},
		'{FUNC_BYTE,  8'h34, 1'b1, ERR_NONE,         1'b0, 1'b0},
		'{FUNC_BYTE,  8'h56, 1'b1, ERR_NONE,         1'b0, 1'b0},
		'{FUNC_BYTE,  8'h78, 1'b1, ERR_NONE,         1'b1, 1'b0},
		'{FUNC_BYTE,  8'hFF, 1'b0, ERR_NONE,         1'b0, 1'b0},  // payload
		'{FUNC_BYTE,  8'h00, 1'b1, ERR_NONE,         1'b0, 1'b1},
		'{FUNC_BYTE,  8'h08, 1'b1, ERR_NONE,         1'b0, 1'b0},  // close without fin
		'{FUNC_BYTE,  8'h80, 1'b1, ERR_NONE,         1'b0, 1'b0},
		'{FUNC_BYTE,  8'h00, 1'b1, ERR_NONE,         1'b0, 1'b0},
		'{FUNC_BYTE,  8'hFF, 1'b1, ERR_NONE,         1'b0, 1'b0},
		'{FUNC_BYTE,  8'h00, 1'b1, ERR_NONE,         1'b0, 1'b0},
		'{FUNC_BYTE,  8'hFF, 1'b1, ERR_FRAG_CTRL,    1'b0, 1'b0},
		'{FUNC_BYTE,  8'h55, 1'b1, ERR_FRAG_CTRL,    1'b0, 1'b0},  // sticky error
		'{FUNC_CLEAR, 8'hFF, 1'b1, ERR_NONE,         1'b0, 1'b0},
		'{FUNC_BYTE,  8'h89, 1'b1, ERR_NONE,         1'b0, 1'b0},  // unmasked ping
		'{FUNC_BYTE,  8'h00, 1'b1, ERR_MISSING_MASK, 1'b0, 1'b0},
		'{FUNC_CLEAR, 8'h00, 1'b1, ERR_NONE,         1'b0, 1'b0}
	};

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FUNC_BYTE;
		cfg_valid = 1'b0;
		cfg_index = CFG_ROLE;
		cfg_data = '0;
		role = ROLE_SERVER;
		rsv_mask = 3'b000;
		max_len = '0;
		clear_parser();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < 25; k++) begin
			send_item(directed_rows[k].func, directed_rows[k].data, directed_rows[k].pinned,
				directed_rows[k].err, directed_rows[k].hdr, directed_rows[k].last);
		end
		run_phase(PHASE_ITEMS);

		apply_setting(ROLE_CLIENT, 3'b111, {LEN_W{1'b1}});
		run_phase(PHASE_ITEMS);
		apply_setting(ROLE_SERVER, 3'($urandom), len_t'(1));
		run_phase(PHASE_ITEMS);
		apply_setting(ROLE_CLIENT, 3'b000, len_t'($urandom_range(20, 200)));
		run_phase(PHASE_ITEMS);
		apply_setting(1'($urandom), 3'($urandom), len_t'({$urandom, $urandom}));
		run_phase(PHASE_ITEMS);

		// last stretch runs at full rate on both sides
		drain();
		idle_on = 1'b0;
		apply_setting(ROLE_SERVER, 3'b101, '0);
		run_phase(PHASE_ITEMS);

		drain();
		if (mismatches == 0)
			$display("websocket_frame_parser test passed");
		else
			$display("websocket_frame_parser test failed");
		$finish;
	end

endmodule
